// File: rtl/eoi_pkg.sv
`timescale 1ns / 1ps
package eoi_pkg;
	localparam int MAXP    = 8;
	localparam int IDX_W   = 3;
	localparam int CNTP_W  = IDX_W + 1;
	localparam int F       = 32;
	localparam int W       = 48;
	localparam int CFG_W   = 47;
	localparam int OE_W    = 16;
	localparam int NUM_W   = W + F;
	localparam int PROD_W  = 2 * W;
	localparam int MAG_W   = PROD_W - F;
	localparam int REM_W   = W + 4;
	localparam int STEP_W  = 7;

	localparam logic signed [W-1:0] MAXW = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] MINW = {1'b1, {(W-1){1'b0}}};

	localparam logic CMD_INIT    = 1'b0;
	localparam logic CMD_ADVANCE = 1'b1;

	typedef enum logic [1:0] {
		REG_G_NORM       = 2'd0,
		REG_STEP_SIZE    = 2'd1,
		REG_OUTPUT_EVERY = 2'd2,
		REG_PLANET_COUNT = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		OP_MUL  = 3'b001,
		OP_DIV  = 3'b010,
		OP_SQRT = 3'b100
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_ctl_t;

	function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
		return v[W-1] ? W'(-v) : W'(v);
	endfunction

	function automatic logic signed [W-1:0] with_sign(input logic [MAG_W-1:0] m,
			input logic neg);
		logic [W-1:0] lo;
		lo = m[W-1:0];
		if (!neg) begin
			return (m > MAG_W'(MAXW)) ? MAXW : lo;
		end else if (m > MAG_W'(MAXW) + MAG_W'(1)) begin
			return MINW;
		end else begin
			return W'(-lo);
		end
	endfunction

	function automatic logic signed [W-1:0] sadd(input logic signed [W-1:0] a,
			input logic signed [W-1:0] b);
		logic [W:0] s;
		s = {a[W-1], a} + {b[W-1], b};
		if (s[W] != s[W-1]) begin
			return s[W] ? MINW : MAXW;
		end
		return s[W-1:0];
	endfunction
endpackage

// File: rtl/eoi_if.sv
`timescale 1ns / 1ps
interface eoi_in_if import eoi_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             cmd;
	logic [IDX_W-1:0] planet_index;
	logic [CFG_W-1:0] radius;
	modport source (output valid, cmd, planet_index, radius, input ready);
	modport sink (input valid, cmd, planet_index, radius, output ready);
endinterface

interface eoi_out_if import eoi_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [IDX_W-1:0]    out_planet;
	logic signed [W-1:0] out_time;
	logic signed [W-1:0] out_x;
	logic signed [W-1:0] out_y;
	logic signed [W-1:0] out_vx;
	logic signed [W-1:0] out_vy;
	logic signed [W-1:0] out_ax;
	logic signed [W-1:0] out_ay;
	logic                last;
	modport source (output valid, out_planet, out_time, out_x, out_y, out_vx, out_vy,
		out_ax, out_ay, last, input ready);
	modport sink (input valid, out_planet, out_time, out_x, out_y, out_vx, out_vy,
		out_ax, out_ay, last, output ready);
endinterface

// File: rtl/euler_orbit_integrator_unit.sv
// An init sets up one planet and yields its record; an advance steps every
// active planet and, when the output-every count is reached, emits one record
// per active planet. Throughput: one item at a time; a new beat is taken only
// while idle, once the last item and its records are finished. One serial
// multiply, divide and square root unit performs every operation.
// Reset: arst_n clears all planet state, time, counter and handshakes at once,
// and loads the registers with their default values.
`timescale 1ns / 1ps
module euler_orbit_integrator_unit import eoi_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	eoi_in_if.sink           in_ch,
	eoi_out_if.source        out_ch
);
	typedef enum logic [16:0] {
		S_IDLE  = 17'h00001,
		S_QDIV  = 17'h00002,
		S_VSQRT = 17'h00004,
		S_PX    = 17'h00008,
		S_PY    = 17'h00010,
		S_VX    = 17'h00020,
		S_VY    = 17'h00040,
		S_SQX   = 17'h00080,
		S_SQY   = 17'h00100,
		S_ROOT  = 17'h00200,
		S_TDIV  = 17'h00400,
		S_KDIV  = 17'h00800,
		S_UXDIV = 17'h01000,
		S_AXMUL = 17'h02000,
		S_UYDIV = 17'h04000,
		S_AYMUL = 17'h08000,
		S_EMIT  = 17'h10000
	} state_t;

	state_t state_q;

	logic [CFG_W-1:0]  g_q;
	logic [CFG_W-1:0]  step_q;
	logic [OE_W-1:0]   oe_q;
	logic [CNTP_W-1:0] pc_q;

	logic signed [W-1:0] px_q [MAXP];
	logic signed [W-1:0] py_q [MAXP];
	logic signed [W-1:0] vx_q [MAXP];
	logic signed [W-1:0] vy_q [MAXP];
	logic signed [W-1:0] ax_q [MAXP];
	logic signed [W-1:0] ay_q [MAXP];
	logic signed [W-1:0] time_q;
	logic [OE_W-1:0]     cnt_q;

	logic              cmd_q;
	logic              emit_q;
	logic              issued_q;
	logic [IDX_W-1:0]  pl_q;
	logic [CNTP_W-1:0] n_q;
	logic [CFG_W-1:0]  rad_q;
	logic [W-1:0]      k_q;
	logic [W-1:0]      r_q;
	logic [W-1:0]      u_q;
	logic [PROD_W-1:0] sq_q;

	logic                ov_q;
	logic [IDX_W-1:0]    o_pl_q;
	logic signed [W-1:0] o_t_q, o_x_q, o_y_q, o_vx_q, o_vy_q, o_ax_q, o_ay_q;
	logic                o_last_q;

	alu_ctl_t          alu_ctl;
	logic [W-1:0]      opa, opb;
	logic [PROD_W-1:0] rad;
	logic              alu_done;
	logic [PROD_W-1:0] alu_res;

	logic                accept;
	logic                fire;
	logic                load;
	logic                last_rec;
	logic [W-1:0]        h;
	logic [W-1:0]        mx, my;
	logic signed [W-1:0] cur_px, cur_py;
	logic [PROD_W-1:0]   sq_sum;
	logic [OE_W-1:0]     cnt_nx;
	logic [CNTP_W-1:0]   pc_lim;
	logic [CNTP_W-1:0]   pl_nx;
	logic [MAG_W-1:0]    prod_hi;

	assign accept   = in_ch.valid && in_ch.ready;
	assign fire     = issued_q && alu_done;
	assign load     = (state_q == S_EMIT) && (!ov_q || out_ch.ready);
	assign pl_nx    = {1'b0, pl_q} + CNTP_W'(1);
	assign last_rec = (cmd_q == CMD_INIT) || (pl_nx == n_q);
	assign h        = {1'b0, step_q};
	assign cur_px   = px_q[pl_q];
	assign cur_py   = py_q[pl_q];
	assign mx       = mag(cur_px);
	assign my       = mag(cur_py);
	assign sq_sum   = sq_q + alu_res;
	assign cnt_nx   = cnt_q + OE_W'(1);
	assign pc_lim   = (pc_q > CNTP_W'(MAXP)) ? CNTP_W'(MAXP) : pc_q;
	assign prod_hi  = alu_res[PROD_W-1:F];

	assign in_ch.ready = (state_q == S_IDLE);

	always_comb begin
		alu_ctl.start = issued_q == 1'b0 && state_q != S_IDLE && state_q != S_EMIT;
		alu_ctl.op    = OP_MUL;
		opa           = '0;
		opb           = '0;
		rad           = sq_q;
		unique case (state_q)
			S_QDIV: begin
				alu_ctl.op = OP_DIV;
				opa        = {1'b0, g_q};
				opb        = {1'b0, rad_q};
			end
			S_VSQRT: begin
				alu_ctl.op = OP_SQRT;
				rad        = PROD_W'({k_q, {F{1'b0}}});
			end
			S_PX: begin opa = mag(vx_q[pl_q]); opb = h; end
			S_PY: begin opa = mag(vy_q[pl_q]); opb = h; end
			S_VX: begin opa = mag(ax_q[pl_q]); opb = h; end
			S_VY: begin opa = mag(ay_q[pl_q]); opb = h; end
			S_SQX: begin opa = mx; opb = mx; end
			S_SQY: begin opa = my; opb = my; end
			S_ROOT: alu_ctl.op = OP_SQRT;
			S_TDIV: begin alu_ctl.op = OP_DIV; opa = {1'b0, g_q}; opb = r_q; end
			S_KDIV: begin alu_ctl.op = OP_DIV; opa = k_q; opb = r_q; end
			S_UXDIV: begin alu_ctl.op = OP_DIV; opa = mx; opb = r_q; end
			S_UYDIV: begin alu_ctl.op = OP_DIV; opa = my; opb = r_q; end
			S_AXMUL, S_AYMUL: begin opa = k_q; opb = u_q; end
			default: alu_ctl.op = OP_MUL;
		endcase
	end

	eoi_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (alu_ctl),
		.opa    (opa),
		.opb    (opb),
		.rad    (rad),
		.done   (alu_done),
		.res    (alu_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			g_q    <= 47'd169558514544;
			step_q <= 47'd4294967;
			oe_q   <= OE_W'(1);
			pc_q   <= CNTP_W'(MAXP);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_G_NORM:       g_q    <= cfg_data;
				REG_STEP_SIZE:    step_q <= cfg_data;
				REG_OUTPUT_EVERY: oe_q   <= cfg_data[OE_W-1:0];
				REG_PLANET_COUNT: pc_q   <= cfg_data[CNTP_W-1:0];
				default:          g_q    <= g_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			issued_q <= 1'b0;
			cmd_q    <= CMD_INIT;
			emit_q   <= 1'b0;
			pl_q     <= '0;
			n_q      <= '0;
			time_q   <= '0;
			cnt_q    <= '0;
			for (int i = 0; i < MAXP; i++) begin
				px_q[i] <= '0;
				py_q[i] <= '0;
				vx_q[i] <= '0;
				vy_q[i] <= '0;
				ax_q[i] <= '0;
				ay_q[i] <= '0;
			end
		end else begin
			if (alu_ctl.start) begin
				issued_q <= 1'b1;
			end else if (fire) begin
				issued_q <= 1'b0;
			end
			priority case (1'b1)
				accept: begin
					cmd_q <= in_ch.cmd;
					if (in_ch.cmd == CMD_INIT) begin
						pl_q                     <= in_ch.planet_index;
						rad_q                    <= in_ch.radius;
						px_q[in_ch.planet_index] <= W'(-{1'b0, in_ch.radius});
						py_q[in_ch.planet_index] <= '0;
						vx_q[in_ch.planet_index] <= '0;
						vy_q[in_ch.planet_index] <= '0;
						time_q                   <= '0;
						cnt_q                    <= '0;
						state_q <= (in_ch.radius == '0) ? S_SQX : S_QDIV;
					end else begin
						pl_q   <= '0;
						n_q    <= pc_lim;
						time_q <= sadd(time_q, h);
						emit_q <= (cnt_nx >= oe_q) || (cnt_nx == '0);
						cnt_q  <= ((cnt_nx >= oe_q) || (cnt_nx == '0)) ? '0 : cnt_nx;
						state_q <= (pc_lim == '0) ? S_IDLE : S_PX;
					end
				end
				load: begin
					if (last_rec) begin
						state_q <= S_IDLE;
					end else begin
						pl_q <= pl_nx[IDX_W-1:0];
					end
				end
				fire: begin
					unique case (state_q)
						S_QDIV: begin
							k_q     <= alu_res[W-1:0];
							state_q <= S_VSQRT;
						end
						S_VSQRT: begin
							vy_q[pl_q] <= alu_res[W-1:0];
							state_q    <= S_SQX;
						end
						S_PX: begin
							px_q[pl_q] <= sadd(cur_px, with_sign(prod_hi, vx_q[pl_q][W-1]));
							state_q    <= S_PY;
						end
						S_PY: begin
							py_q[pl_q] <= sadd(cur_py, with_sign(prod_hi, vy_q[pl_q][W-1]));
							state_q    <= S_VX;
						end
						S_VX: begin
							vx_q[pl_q] <= sadd(vx_q[pl_q], with_sign(prod_hi, ax_q[pl_q][W-1]));
							state_q    <= S_VY;
						end
						S_VY: begin
							vy_q[pl_q] <= sadd(vy_q[pl_q], with_sign(prod_hi, ay_q[pl_q][W-1]));
							state_q    <= S_SQX;
						end
						S_SQX: begin
							sq_q    <= alu_res;
							state_q <= S_SQY;
						end
						S_SQY: begin
							sq_q <= sq_sum;
							if (sq_sum == '0) begin
								ax_q[pl_q] <= '0;
								ay_q[pl_q] <= '0;
								if (cmd_q == CMD_INIT) begin
									state_q <= S_EMIT;
								end else if (pl_nx < n_q) begin
									pl_q    <= pl_nx[IDX_W-1:0];
									state_q <= S_PX;
								end else begin
									pl_q    <= '0;
									state_q <= emit_q ? S_EMIT : S_IDLE;
								end
							end else begin
								state_q <= S_ROOT;
							end
						end
						S_ROOT: begin
							r_q     <= alu_res[W-1:0];
							state_q <= S_TDIV;
						end
						S_TDIV: begin
							k_q     <= alu_res[W-1:0];
							state_q <= S_KDIV;
						end
						S_KDIV: begin
							k_q     <= alu_res[W-1:0];
							state_q <= S_UXDIV;
						end
						S_UXDIV: begin
							u_q     <= alu_res[W-1:0];
							state_q <= S_AXMUL;
						end
						S_AXMUL: begin
							ax_q[pl_q] <= with_sign(prod_hi, cur_px > 0);
							state_q    <= S_UYDIV;
						end
						S_UYDIV: begin
							u_q     <= alu_res[W-1:0];
							state_q <= S_AYMUL;
						end
						S_AYMUL: begin
							ay_q[pl_q] <= with_sign(prod_hi, cur_py > 0);
							if (cmd_q == CMD_INIT) begin
								state_q <= S_EMIT;
							end else if (pl_nx < n_q) begin
								pl_q    <= pl_nx[IDX_W-1:0];
								state_q <= S_PX;
							end else begin
								pl_q    <= '0;
								state_q <= emit_q ? S_EMIT : S_IDLE;
							end
						end
						default: state_q <= S_IDLE;
					endcase
				end
				default: state_q <= state_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (load) begin
			ov_q <= 1'b1;
		end else if (out_ch.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			o_pl_q   <= pl_q;
			o_t_q    <= time_q;
			o_x_q    <= cur_px;
			o_y_q    <= cur_py;
			o_vx_q   <= vx_q[pl_q];
			o_vy_q   <= vy_q[pl_q];
			o_ax_q   <= ax_q[pl_q];
			o_ay_q   <= ay_q[pl_q];
			o_last_q <= last_rec;
		end
	end

	assign out_ch.valid      = ov_q;
	assign out_ch.out_planet = o_pl_q;
	assign out_ch.out_time   = o_t_q;
	assign out_ch.out_x      = o_x_q;
	assign out_ch.out_y      = o_y_q;
	assign out_ch.out_vx     = o_vx_q;
	assign out_ch.out_vy     = o_vy_q;
	assign out_ch.out_ax     = o_ax_q;
	assign out_ch.out_ay     = o_ay_q;
	assign out_ch.last       = o_last_q;
endmodule

// File: rtl/eoi_alu.sv
`timescale 1ns / 1ps
module eoi_alu import eoi_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  alu_ctl_t          ctl,
	input  logic [W-1:0]      opa,
	input  logic [W-1:0]      opb,
	input  logic [PROD_W-1:0] rad,
	output logic              done,
	output logic [PROD_W-1:0] res
);
	logic              busy_q;
	logic              done_q;
	alu_op_t           op_q;
	logic [STEP_W-1:0] cnt_q;
	logic [PROD_W-1:0] prod_q;
	logic [W-1:0]      opd_q;
	logic [REM_W-1:0]  rem_q;
	logic [W-1:0]      root_q;

	logic [W:0]       mul_sum;
	logic [W:0]       div_rem;
	logic [REM_W-1:0] sq_rem;
	logic [REM_W-1:0] sq_trial;
	logic [NUM_W-1:0] quo;

	assign mul_sum  = {1'b0, prod_q[PROD_W-1:W]} + (prod_q[0] ? {1'b0, opd_q} : '0);
	assign div_rem  = {rem_q[W-1:0], prod_q[NUM_W-1]};
	assign sq_rem   = {rem_q[REM_W-3:0], prod_q[PROD_W-1:PROD_W-2]};
	assign sq_trial = {2'b00, root_q, 2'b01};
	assign quo      = prod_q[NUM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= OP_MUL;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				op_q   <= ctl.op;
				cnt_q  <= (ctl.op == OP_DIV) ? STEP_W'(NUM_W) :
					(ctl.op == OP_SQRT) ? STEP_W'(PROD_W / 2) : STEP_W'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q  <= '0;
			root_q <= '0;
			opd_q  <= (ctl.op == OP_MUL) ? opa : opb;
			unique case (ctl.op)
				OP_MUL:  prod_q <= {{W{1'b0}}, opb};
				OP_DIV:  prod_q <= PROD_W'({opa, {F{1'b0}}});
				OP_SQRT: prod_q <= rad;
				default: prod_q <= '0;
			endcase
		end else if (busy_q) begin
			unique case (op_q)
				OP_MUL: begin
					prod_q <= {mul_sum, prod_q[W-1:1]};
				end
				OP_DIV: begin
					if (div_rem >= {1'b0, opd_q}) begin
						rem_q  <= REM_W'(div_rem - {1'b0, opd_q});
						prod_q <= PROD_W'({quo[NUM_W-2:0], 1'b1});
					end else begin
						rem_q  <= REM_W'(div_rem);
						prod_q <= PROD_W'({quo[NUM_W-2:0], 1'b0});
					end
				end
				OP_SQRT: begin
					prod_q <= {prod_q[PROD_W-3:0], 2'b00};
					if (sq_rem >= sq_trial) begin
						rem_q  <= sq_rem - sq_trial;
						root_q <= {root_q[W-2:0], 1'b1};
					end else begin
						rem_q  <= sq_rem;
						root_q <= {root_q[W-2:0], 1'b0};
					end
				end
				default: prod_q <= prod_q;
			endcase
		end
	end

	always_comb begin
		unique case (op_q)
			OP_MUL:  res = prod_q;
			OP_DIV:  res = PROD_W'((|quo[NUM_W-1:W-1]) ? MAXW : {1'b0, quo[W-2:0]});
			OP_SQRT: res = PROD_W'(root_q);
			default: res = '0;
		endcase
	end

	assign done = done_q;
endmodule

// File: rtl/eoi_checker.sv
`timescale 1ns / 1ps
module eoi_checker import eoi_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [IDX_W-1:0]    out_planet,
	input logic signed [W-1:0] out_x,
	input logic                out_last
);
	a_out_known: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !$isunknown(out_planet) && !$isunknown(out_last))
		else $error("output beat carries unknown bits");

	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && !in_valid |=> in_ready)
		else $error("block left idle without an input beat");

	a_out_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_planet) && $stable(out_x)
			&& $stable(out_last))
		else $error("output payload changed while stalled");
endmodule

bind euler_orbit_integrator_unit eoi_checker u_eoi_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.out_planet (out_ch.out_planet),
	.out_x      (out_ch.out_x),
	.out_last   (out_ch.last)
);

// File: verif/eoi_orbit_checker.sv
`timescale 1ns / 1ps
module eoi_orbit_checker import eoi_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	eoi_in_if.sink           in_mon,
	eoi_out_if.sink          out_mon,
	output int               fail_count,
	output int               records_pending,
	output int               records_checked
);
	typedef struct packed {
		logic [IDX_W-1:0] planet;
		logic [W-1:0]     t;
		logic [W-1:0]     x;
		logic [W-1:0]     y;
		logic [W-1:0]     vx;
		logic [W-1:0]     vy;
		logic [W-1:0]     ax;
		logic [W-1:0]     ay;
		logic             last;
	} orbit_rec_t;

	localparam longint WMAX = 64'sd140737488355327;
	localparam longint WMIN = -WMAX - 1;
	localparam logic [63:0] ONE_Q = 64'd1 << F;

	longint px [MAXP];
	longint py [MAXP];
	longint vx [MAXP];
	longint vy [MAXP];
	longint ax [MAXP];
	longint ay [MAXP];
	longint clock_t;
	logic [15:0] countdown;
	logic [CFG_W-1:0] gm, dt;
	logic [15:0] every;
	logic [3:0] active;
	orbit_rec_t expected_recs[$];

	assign records_pending = expected_recs.size();

	function automatic logic [63:0] magnitude(longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic longint signed_sat(logic [63:0] m, logic neg);
		if (!neg) return (m > 64'(WMAX)) ? WMAX : longint'(m);
		if (m > 64'(WMAX) + 64'd1) return WMIN;
		return -longint'(m);
	endfunction

	function automatic logic [63:0] frac_mul(logic [63:0] a, logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		if (p[127:96] != 0) return '1;
		return p[95:32];
	endfunction

	function automatic logic [63:0] scaled_div(logic [63:0] a, logic [63:0] b,
			logic [63:0] d);
		logic [127:0] q;
		if (d == 0) return 64'(WMAX);
		q = ({64'd0, a} * {64'd0, b}) / {64'd0, d};
		if (q > 128'(WMAX)) return 64'(WMAX);
		return q[63:0];
	endfunction

	function automatic logic [63:0] root_floor(logic [127:0] s);
		logic [63:0] res, c;
		res = 0;
		for (int b = 63; b >= 0; b--) begin
			c = res | (64'd1 << b);
			if ({64'd0, c} * {64'd0, c} <= s) res = c;
		end
		return res;
	endfunction

	function automatic longint sat_add(longint a, longint b);
		longint s;
		s = a + b;
		if (s > WMAX) return WMAX;
		if (s < WMIN) return WMIN;
		return s;
	endfunction

	function automatic longint fix_mul(longint a, longint b);
		return signed_sat(frac_mul(magnitude(a), magnitude(b)), (a < 0) != (b < 0));
	endfunction

	task automatic gravity(int i);
		logic [63:0] mx, my, r, t, k;
		logic [127:0] s;
		mx = magnitude(px[i]);
		my = magnitude(py[i]);
		s = {64'd0, mx} * {64'd0, mx} + {64'd0, my} * {64'd0, my};
		if (s == 0) begin
			ax[i] = 0;
			ay[i] = 0;
		end else begin
			r = root_floor(s);
			t = scaled_div(64'(gm), ONE_Q, r);
			k = scaled_div(t, ONE_Q, r);
			ax[i] = signed_sat(frac_mul(k, scaled_div(mx, ONE_Q, r)), px[i] > 0);
			ay[i] = signed_sat(frac_mul(k, scaled_div(my, ONE_Q, r)), py[i] > 0);
		end
	endtask

	task automatic push_record(int i, logic last);
		orbit_rec_t e;
		e.planet = IDX_W'(i);
		e.t = clock_t[W-1:0];
		e.x = px[i][W-1:0];
		e.y = py[i][W-1:0];
		e.vx = vx[i][W-1:0];
		e.vy = vy[i][W-1:0];
		e.ax = ax[i][W-1:0];
		e.ay = ay[i][W-1:0];
		e.last = last;
		expected_recs.push_back(e);
	endtask

	task automatic predict_beat(logic cmd, logic [IDX_W-1:0] idx, logic [CFG_W-1:0] rad);
		int n;
		logic [63:0] r, q;
		if (cmd == CMD_INIT) begin
			r = 64'(rad);
			px[idx] = -longint'(r);
			py[idx] = 0;
			vx[idx] = 0;
			vy[idx] = 0;
			if (r != 0) begin
				q = scaled_div(64'(gm), ONE_Q, r);
				vy[idx] = signed_sat(root_floor({64'd0, q} * {64'd0, ONE_Q}), 1'b0);
			end
			gravity(idx);
			clock_t = 0;
			countdown = 0;
			push_record(idx, 1'b1);
		end else begin
			n = (active > MAXP) ? MAXP : active;
			for (int i = 0; i < n; i++) begin
				px[i] = sat_add(px[i], fix_mul(vx[i], longint'(dt)));
				py[i] = sat_add(py[i], fix_mul(vy[i], longint'(dt)));
				vx[i] = sat_add(vx[i], fix_mul(ax[i], longint'(dt)));
				vy[i] = sat_add(vy[i], fix_mul(ay[i], longint'(dt)));
			end
			clock_t = sat_add(clock_t, longint'(dt));
			for (int i = 0; i < n; i++) gravity(i);
			countdown = countdown + 16'd1;
			if (countdown >= every || countdown == 0) begin
				countdown = 0;
				for (int i = 0; i < n; i++) push_record(i, i + 1 == n);
			end
		end
	endtask

	task automatic check_field(string name, logic [W-1:0] e, logic [W-1:0] a);
		if (e !== a) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, e, a);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		orbit_rec_t e;
		if (!arst_n) begin
			for (int i = 0; i < MAXP; i++) begin
				px[i] = 0; py[i] = 0; vx[i] = 0; vy[i] = 0; ax[i] = 0; ay[i] = 0;
			end
			clock_t = 0;
			countdown = 0;
			gm = 47'd169558514544;
			dt = 47'd4294967;
			every = 16'd1;
			active = 4'd8;
			fail_count = 0;
			records_checked = 0;
			expected_recs.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_G_NORM:       gm = cfg_data;
					REG_STEP_SIZE:    dt = cfg_data;
					REG_OUTPUT_EVERY: every = cfg_data[15:0];
					REG_PLANET_COUNT: active = cfg_data[3:0];
					default: ;
				endcase
			end
			if (in_mon.valid && in_mon.ready)
				predict_beat(in_mon.cmd, in_mon.planet_index, in_mon.radius);
			if (out_mon.valid && out_mon.ready) begin
				records_checked++;
				if (expected_recs.size() == 0) begin
					$display("%0t: unexpected record for planet %0d", $time,
						out_mon.out_planet);
					fail_count++;
				end else begin
					e = expected_recs.pop_front();
					check_field("planet", W'(e.planet), W'(out_mon.out_planet));
					check_field("time", e.t, out_mon.out_time);
					check_field("x", e.x, out_mon.out_x);
					check_field("y", e.y, out_mon.out_y);
					check_field("vx", e.vx, out_mon.out_vx);
					check_field("vy", e.vy, out_mon.out_vy);
					check_field("ax", e.ax, out_mon.out_ax);
					check_field("ay", e.ay, out_mon.out_ay);
					check_field("last", W'(e.last), W'(out_mon.last));
				end
			end
		end
	end
endmodule

// File: verif/tb_euler_orbit_integrator_unit.sv
`timescale 1ns / 1ps
module tb_euler_orbit_integrator_unit;
	import eoi_pkg::*;

	localparam int CYCLE_LIMIT = 12000000;
	localparam int SETTLE = 7000;
	localparam logic [CFG_W-1:0] REG_MAX = '1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = REG_G_NORM;
	logic [CFG_W-1:0] cfg_data = '0;
	bit hold_req = 1'b0;
	int fail_count, records_pending, records_checked;
	int beats_sent = 0;
	int cycles = 0;

	eoi_in_if in_ch ();
	eoi_out_if out_ch ();

	euler_orbit_integrator_unit dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	eoi_orbit_checker checker_i (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_mon(in_ch.sink), .out_mon(out_ch.sink),
		.fail_count(fail_count), .records_pending(records_pending),
		.records_checked(records_checked)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic int gap_len();
		if ($urandom_range(0, 19) == 0) return $urandom_range(40, 300);
		if ($urandom_range(0, 2) == 0) return 0;
		return $urandom_range(1, 4);
	endfunction

	initial begin
		out_ch.ready = 1'b0;
		wait (arst_n);
		forever begin
			if (hold_req) begin
				out_ch.ready <= 1'b0;
				repeat (20000) @(posedge clk);
				hold_req = 1'b0;
			end
			out_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 30)) @(posedge clk);
			if ($urandom_range(0, 3) != 0) begin
				out_ch.ready <= 1'b0;
				repeat (gap_len() + 1) @(posedge clk);
			end
		end
	end

	task automatic send_beat(logic cmd, logic [IDX_W-1:0] idx, logic [CFG_W-1:0] rad);
		int g;
		in_ch.valid <= 1'b1;
		in_ch.cmd <= cmd;
		in_ch.planet_index <= idx;
		in_ch.radius <= rad;
		do @(posedge clk); while (!in_ch.ready);
		beats_sent++;
		g = gap_len();
		if (g > 0) begin
			in_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (records_pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_regs(logic [CFG_W-1:0] g, logic [CFG_W-1:0] h,
			logic [15:0] every, logic [3:0] count);
		cfg_we <= 1'b1;
		cfg_index <= REG_G_NORM;
		cfg_data <= g;
		@(posedge clk);
		cfg_index <= REG_STEP_SIZE;
		cfg_data <= h;
		@(posedge clk);
		cfg_index <= REG_OUTPUT_EVERY;
		cfg_data <= CFG_W'(every);
		@(posedge clk);
		cfg_index <= REG_PLANET_COUNT;
		cfg_data <= CFG_W'(count);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [CFG_W-1:0] rand_radius();
		logic [CFG_W-1:0] r;
		case ($urandom_range(0, 9))
			0: r = CFG_W'({$urandom, $urandom});
			1: r = CFG_W'($urandom_range(1, 65535));
			default: r = {15'($urandom_range(0, 40)), 32'($urandom)};
		endcase
		return (r == 0) ? CFG_W'(1) : r;
	endfunction

	task automatic random_run(int count);
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 9) < 4)
				send_beat(CMD_INIT, IDX_W'($urandom_range(0, 7)), rand_radius());
			else
				send_beat(CMD_ADVANCE, IDX_W'($urandom), CFG_W'({$urandom, $urandom}));
		end
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.cmd = CMD_INIT;
		in_ch.planet_index = '0;
		in_ch.radius = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_beat(CMD_INIT, 3'd0, CFG_W'(1));
		send_beat(CMD_INIT, 3'd1, REG_MAX);
		send_beat(CMD_INIT, 3'd2, CFG_W'(64'd1 << 32));
		send_beat(CMD_INIT, 3'd3, CFG_W'(64'd5 << 32));
		send_beat(CMD_INIT, 3'd4, CFG_W'(64'd3 << 31));
		send_beat(CMD_INIT, 3'd5, CFG_W'(64'd1 << 16));
		send_beat(CMD_INIT, 3'd6, CFG_W'(64'd1 << 40));
		send_beat(CMD_INIT, 3'd7, 47'h2AAA_AAAA_AAAA);
		send_beat(CMD_ADVANCE, 3'd7, 47'h5555_5555_5555);
		send_beat(CMD_ADVANCE, 3'd0, '0);
		send_beat(CMD_INIT, 3'd3, CFG_W'(64'd2 << 32));
		send_beat(CMD_ADVANCE, 3'd5, REG_MAX);
		send_beat(CMD_ADVANCE, 3'd2, '0);
		random_run(8);
		drain();

		write_regs(REG_MAX, CFG_W'(1), 16'd1, 4'd1);
		hold_req = 1'b1;
		random_run(80);
		drain();

		write_regs(CFG_W'(1), REG_MAX, 16'd3, 4'd2);
		random_run(70);
		drain();

		write_regs(CFG_W'({$urandom, $urandom}), CFG_W'($urandom_range(1, 1 << 24)),
			16'd65535, 4'd1);
		random_run(40);
		drain();

		write_regs(47'd169558514544, CFG_W'($urandom_range(1, 1 << 26)), 16'd2, 4'd3);
		random_run(90);
		drain();

		write_regs(CFG_W'(64'd39 << 32), CFG_W'(64'd1 << 20), 16'd1, 4'd8);
		random_run(12);
		drain();

		write_regs(CFG_W'({$urandom, $urandom}), CFG_W'($urandom_range(1, 1 << 22)),
			16'd1, 4'd2);
		random_run(157);
		drain();

		$display("Sent %0d input beats over seven register settings; checked %0d records.",
			beats_sent, records_checked);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
